/* src/atop_pkg.sv */
// ----------------------------------------------------------------------------
// atop_pkg
// Shared widths, codes and controller/datapath interface types for the
// adaptive-threshold onset picker.
// ----------------------------------------------------------------------------
package atop_pkg;

  // Window and ring geometry
  localparam int HALF_WINDOW = 43;
  localparam int RING_DEPTH  = 128;
  localparam int RING_AW     = $clog2(RING_DEPTH);

  // Field widths
  localparam int FEAT_W  = 16;
  localparam int SCORE_W = 18;
  localparam int TIME_W  = 32;
  localparam int TAG_W   = 4;
  localparam int CNT_W   = 8;

  // Running window statistics
  localparam int SUM_W  = 25;
  localparam int SQ_W   = 43;
  localparam int SQ1_W  = 2 * SCORE_W;

  // Threshold arithmetic: n*score - sum, squares, spread and final compare
  localparam int N_W    = $clog2(2 * HALF_WINDOW + 1);
  localparam int NS_W   = N_W + SCORE_W;
  localparam int D_W    = SUM_W + 1;
  localparam int DSQ_W  = 2 * (D_W - 1);
  localparam int SSQ_W  = 2 * SUM_W;
  localparam int NSQ_W  = N_W + SQ_W;
  localparam int SPR_W  = ((NSQ_W > SSQ_W) ? NSQ_W : SSQ_W) + 1;
  localparam int CMP_W  = SPR_W + 5;

  // Judge offset starts one short of the half window; drop offset is k + H + 1
  localparam logic [RING_AW-1:0] K_START  = RING_AW'(HALF_WINDOW - 1);
  localparam logic [RING_AW-1:0] DROP_OFS = RING_AW'(HALF_WINDOW + 1);
  localparam logic [CNT_W-1:0]   CNT_MAX  = '1;

  // Ring read selection
  typedef enum logic [1:0] {
    RD_NONE,
    RD_DROP,
    RD_PEAK,
    RD_RIGHT
  } rd_sel_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_FETCH,
    ST_DROP,
    ST_RD2,
    ST_C1,
    ST_C2,
    ST_C3,
    ST_C4,
    ST_WRAP,
    ST_NEXT,
    ST_END
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic    accept;
    logic    win_add;
    logic    win_sub;
    rd_sel_t rd_sel;
    logic    judge_run;
    logic    emit_peak;
    logic    emit_end;
    logic    advance;
    logic    k_dec;
    logic    restart;
  } atop_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic drop_ok;
    logic judge_ok;
    logic k_is_one;
    logic last;
    logic hit;
    logic out_free;
  } atop_status_t;

endpackage

/* src/atop_ctrl.sv */
// ----------------------------------------------------------------------------
// atop_ctrl
// Sequencer for the onset picker: one window add per frame, then one
// drop/judge step (or a walk of steps on the final frame), then end marker.
// ----------------------------------------------------------------------------
module atop_ctrl
  import atop_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  atop_status_t status,
  output atop_cmd_t    cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_ADD;
      end
      ST_ADD:   state_next = ST_DROP;
      ST_FETCH: state_next = ST_DROP;
      ST_DROP: begin
        state_next = status.judge_ok ? ST_RD2 : ST_NEXT;
      end
      ST_RD2: state_next = ST_C1;
      ST_C1:  state_next = ST_C2;
      ST_C2:  state_next = ST_C3;
      ST_C3:  state_next = ST_C4;
      ST_C4:  state_next = ST_WRAP;
      ST_WRAP: begin
        if (!status.hit || status.out_free) state_next = ST_NEXT;
      end
      ST_NEXT: begin
        if (!status.last) begin
          state_next = ST_IDLE;
        end else if (!status.k_is_one) begin
          state_next = ST_FETCH;
        end else begin
          state_next = ST_END;
        end
      end
      ST_END: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        cmd.rd_sel = RD_DROP;
      end
      ST_ADD: begin
        cmd.win_add = 1'b1;
      end
      ST_FETCH: begin
        cmd.rd_sel = RD_DROP;
      end
      ST_DROP: begin
        cmd.win_sub = status.drop_ok;
        cmd.rd_sel  = RD_PEAK;
      end
      ST_RD2: begin
        cmd.rd_sel = RD_RIGHT;
      end
      ST_C1, ST_C2, ST_C3, ST_C4: begin
        cmd.judge_run = 1'b1;
      end
      ST_WRAP: begin
        cmd.emit_peak = status.hit && status.out_free;
      end
      ST_NEXT: begin
        cmd.advance = !status.last;
        cmd.k_dec   = status.last && !status.k_is_one;
      end
      ST_END: begin
        cmd.emit_end = status.out_free;
        cmd.restart  = status.out_free;
      end
      default: ;
    endcase
  end

endmodule

/* src/atop_datapath.sv */
// ----------------------------------------------------------------------------
// atop_datapath
// Score/time rings, running window sum and sum of squares, the staged
// mean-plus-1.5-sigma test and the output register.
// ----------------------------------------------------------------------------
module atop_datapath
  import atop_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [TAG_W-1:0]   cfg_data,
  input  logic [FEAT_W-1:0]  total_flux,
  input  logic [FEAT_W-1:0]  chroma_flux,
  input  logic [FEAT_W-1:0]  percussive_energy,
  input  logic [TIME_W-1:0]  frame_time_ms,
  input  logic               end_of_stream,
  input  logic               out_stall,
  output logic               out_valid,
  output logic               peak_valid,
  output logic [TIME_W-1:0]  onset_time_ms,
  output logic [SCORE_W-1:0] onset_score,
  output logic [TAG_W-1:0]   onset_tag,
  output logic               stream_done,
  input  atop_cmd_t          cmd,
  output atop_status_t       status
);

  // Configuration
  logic [TAG_W-1:0]   stem_tag;

  // Stream state
  logic [CNT_W-1:0]   frames_seen;
  logic [RING_AW-1:0] wp;
  logic [RING_AW-1:0] k;
  logic [SUM_W-1:0]   sum;
  logic [SQ_W-1:0]    sumsq;

  // Current frame
  logic [SCORE_W-1:0] cur_score;
  logic [CNT_W-1:0]   cur_j;
  logic               cur_last;

  // Rings and read registers
  logic [SCORE_W-1:0] score_ring [RING_DEPTH];
  logic [TIME_W-1:0]  time_ring  [RING_DEPTH];
  logic [SCORE_W-1:0] rd_a;
  logic [SCORE_W-1:0] rd_b;
  logic [TIME_W-1:0]  rd_t;
  logic [SCORE_W-1:0] left;

  // Judge pipeline
  logic [N_W-1:0]           n_reg;
  logic                     peak;
  logic signed [D_W-1:0]    d;
  logic [NSQ_W-1:0]         nsq;
  logic                     d_pos;
  logic [DSQ_W-1:0]         dsq;
  logic [SSQ_W-1:0]         ssq;
  logic signed [SPR_W-1:0]  spread;
  logic                     hit;

  // Combinational helpers
  logic [SCORE_W-1:0] score_in;
  logic [SQ1_W-1:0]   cur_sq;
  logic [SQ1_W-1:0]   drop_sq;
  logic [RING_AW-1:0] drop_addr;
  logic [RING_AW-1:0] peak_addr;
  logic [RING_AW-1:0] left_addr;
  logic [RING_AW-1:0] right_addr;
  logic [CNT_W-1:0]   k_ext;
  logic [NS_W-1:0]    ns;
  logic signed [CMP_W-1:0] lhs;
  logic signed [CMP_W-1:0] spread_x;
  logic signed [CMP_W-1:0] rhs;

  assign score_in = SCORE_W'(total_flux) + SCORE_W'(chroma_flux)
                  + SCORE_W'(percussive_energy);
  assign cur_sq   = SQ1_W'(cur_score) * SQ1_W'(cur_score);
  assign drop_sq  = SQ1_W'(rd_a) * SQ1_W'(rd_a);

  // Ring slots relative to the current frame
  assign drop_addr  = wp - (k + DROP_OFS);
  assign peak_addr  = wp - k;
  assign left_addr  = wp - k - RING_AW'(1);
  assign right_addr = wp - k + RING_AW'(1);

  assign k_ext = CNT_W'(k);

  // Status back to the sequencer
  assign status.drop_ok  = cur_j >= (k_ext + CNT_W'(HALF_WINDOW + 1));
  assign status.judge_ok = cur_j > k_ext;
  assign status.k_is_one = (k == RING_AW'(1));
  assign status.last     = cur_last;
  assign status.hit      = hit;
  assign status.out_free = !out_valid || !out_stall;

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      stem_tag <= '0;
    end else if (cfg_write) begin
      stem_tag <= cfg_data;
    end
  end

  // Frame capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_score <= score_in;
      cur_j     <= frames_seen;
      cur_last  <= end_of_stream;
    end
  end

  // Rings: one write, two score read ports and one time read port
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      score_ring[wp] <= score_in;
      time_ring[wp]  <= frame_time_ms;
    end
    case (cmd.rd_sel)
      RD_DROP: begin
        rd_a <= score_ring[drop_addr];
      end
      RD_PEAK: begin
        rd_a <= score_ring[peak_addr];
        rd_b <= score_ring[left_addr];
        rd_t <= time_ring[peak_addr];
      end
      RD_RIGHT: begin
        // keep the left neighbor before port B fetches the right one
        left <= rd_b;
        rd_b <= score_ring[right_addr];
      end
      default: ;
    endcase
  end

  // Window statistics, counters and judge offset
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_seen <= '0;
      wp          <= '0;
      k           <= K_START;
      sum         <= '0;
      sumsq       <= '0;
    end else begin
      if (cmd.win_add) begin
        sum   <= sum + SUM_W'(cur_score);
        sumsq <= sumsq + SQ_W'(cur_sq);
      end else if (cmd.win_sub) begin
        sum   <= sum - SUM_W'(rd_a);
        sumsq <= sumsq - SQ_W'(drop_sq);
      end
      if (cmd.advance) begin
        if (frames_seen != CNT_MAX) frames_seen <= frames_seen + CNT_W'(1);
        wp <= wp + RING_AW'(1);
      end
      if (cmd.k_dec) begin
        k <= k - RING_AW'(1);
      end
      if (cmd.restart) begin
        frames_seen <= '0;
        wp          <= '0;
        k           <= K_START;
        sum         <= '0;
        sumsq       <= '0;
      end
    end
  end

  // Window length, clipped to the stream
  always_ff @(posedge clk) begin
    if (cur_j >= (k_ext + CNT_W'(HALF_WINDOW))) begin
      n_reg <= N_W'(k_ext + CNT_W'(HALF_WINDOW + 1));
    end else begin
      n_reg <= N_W'(cur_j + CNT_W'(1));
    end
  end

  // Judge stages: (1) peak, d, n*sumsq  (2) squares  (3) spread  (4) compare
  assign ns       = NS_W'(n_reg) * NS_W'(rd_a);
  assign lhs      = CMP_W'({dsq, 2'b00});
  assign spread_x = CMP_W'(spread);
  assign rhs      = (spread_x <<< 3) + spread_x;

  always_ff @(posedge clk) begin
    if (cmd.judge_run) begin
      peak   <= (rd_a > left) && (rd_a >= rd_b);
      d      <= D_W'(ns) - D_W'(sum);
      nsq    <= NSQ_W'(n_reg) * NSQ_W'(sumsq);
      d_pos  <= !d[D_W-1] && (d != '0);
      dsq    <= DSQ_W'(d[D_W-2:0]) * DSQ_W'(d[D_W-2:0]);
      ssq    <= SSQ_W'(sum) * SSQ_W'(sum);
      spread <= SPR_W'(nsq) - SPR_W'(ssq);
      hit    <= peak && d_pos && (lhs > rhs);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_peak || cmd.emit_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_peak) begin
      peak_valid    <= 1'b1;
      onset_time_ms <= rd_t;
      onset_score   <= rd_a;
      onset_tag     <= stem_tag;
      stream_done   <= 1'b0;
    end else if (cmd.emit_end) begin
      peak_valid    <= 1'b0;
      onset_time_ms <= '0;
      onset_score   <= '0;
      onset_tag     <= stem_tag;
      stream_done   <= 1'b1;
    end
  end

  // A waiting beat is never overwritten
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_peak || cmd.emit_end) |-> status.out_free)
    else $error("result loaded while output beat still pending");

  // Onset and end marker never collide
  a_emit_one: assert property (@(posedge clk) disable iff (rst)
    !(cmd.emit_peak && cmd.emit_end))
    else $error("onset and end marker emitted together");

  // Ring pointer follows the frame count until the count saturates
  a_wp_track: assert property (@(posedge clk) disable iff (rst)
    (frames_seen != CNT_MAX) |-> (wp == frames_seen[RING_AW-1:0]))
    else $error("write pointer out of step with frame count");

  // Judge offset stays within the flush range
  a_k_range: assert property (@(posedge clk) disable iff (rst)
    (k != '0) && (k <= K_START))
    else $error("judge offset out of range");

endmodule

/* src/adaptive_threshold_onset_picker.sv */
// ----------------------------------------------------------------------------
// adaptive_threshold_onset_picker
// Onset peak picker with a mean plus 1.5 sigma sliding-window threshold.
// ----------------------------------------------------------------------------
// Each input beat is one analysis frame; its score is the sum of the three
// Q8.8 features. A frame is reported when it beats its left neighbor, is not
// below its right one, and clears mean + 1.5*stddev over an 86-frame window
// centered on it (clipped at stream ends), tested exactly in integers.
// Decisions come out 42 frames after the frame they concern; the frame marked
// end_of_stream flushes the pending ones and then sends an end marker with
// stream_done set, after which a new stream starts. Once 43 frames have been
// seen, the sequencer also walks one drop/judge step per frame through the
// ring read ports and the four-stage threshold unit; the final frame adds up
// to 41 further steps (shorter where no decision is due), then the end marker.
// Result back-pressure only holds the block when a new result finds the
// output register still occupied. The user writes stem_tag only while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module adaptive_threshold_onset_picker
  import atop_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [TAG_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [FEAT_W-1:0]  total_flux,
  input  logic [FEAT_W-1:0]  chroma_flux,
  input  logic [FEAT_W-1:0]  percussive_energy,
  input  logic [TIME_W-1:0]  frame_time_ms,
  input  logic               end_of_stream,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               peak_valid,
  output logic [TIME_W-1:0]  onset_time_ms,
  output logic [SCORE_W-1:0] onset_score,
  output logic [TAG_W-1:0]   onset_tag,
  output logic               stream_done
);

  atop_cmd_t    cmd;
  atop_status_t status;

  // Sequencer
  atop_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Rings, window statistics, threshold test, output register
  atop_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_data          (cfg_data),
    .total_flux        (total_flux),
    .chroma_flux       (chroma_flux),
    .percussive_energy (percussive_energy),
    .frame_time_ms     (frame_time_ms),
    .end_of_stream     (end_of_stream),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .peak_valid        (peak_valid),
    .onset_time_ms     (onset_time_ms),
    .onset_score       (onset_score),
    .onset_tag         (onset_tag),
    .stream_done       (stream_done),
    .cmd               (cmd),
    .status            (status)
  );

endmodule

/* tb/adaptive_threshold_onset_picker_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_threshold_onset_picker_test
// Self-checking bench for the mean plus 1.5 sigma onset picker.
// ----------------------------------------------------------------------------
// Frames go in as streams closed by end_of_stream. A scoreboard class keeps
// its own copy of the score/time history and the running window sums, decides
// which frames are onsets and queues the onset beats plus the end marker.
// Every result beat is checked field by field against the oldest queued one.
// A few directed streams cover the extremes (lone frame, two and three frame
// streams, plateaus, full-scale scores); random streams with quiet noise and
// sparse spikes follow, including one long enough to saturate the frame
// counter. The sender works in bursts, the receiver stalls in moods and once
// holds off long enough to back the block up; stem_tag changes between
// streams while the block is idle.
// ----------------------------------------------------------------------------
module adaptive_threshold_onset_picker_test;
  import atop_pkg::*;

  typedef struct {
    logic [FEAT_W-1:0] total_flux;
    logic [FEAT_W-1:0] chroma_flux;
    logic [FEAT_W-1:0] percussive_energy;
    logic [TIME_W-1:0] frame_time_ms;
    logic              end_of_stream;
  } frame_t;

  typedef struct {
    logic               peak_valid;
    logic [TIME_W-1:0]  onset_time_ms;
    logic [SCORE_W-1:0] onset_score;
    logic [TAG_W-1:0]   onset_tag;
    logic               stream_done;
  } onset_t;

  // Scoreboard: predicts onset beats per frame and checks the result beats
  class onset_tracker;
    logic [SCORE_W-1:0] score_hist [RING_DEPTH];
    logic [TIME_W-1:0]  time_hist [RING_DEPTH];
    logic [SUM_W-1:0]   run_sum;
    logic [SQ_W-1:0]    run_sq;
    int                 seen;
    logic [RING_AW-1:0] slot;
    logic [TAG_W-1:0]   tag;
    onset_t             due [$];
    int                 errors;
    int                 onsets;
    int                 markers;

    function new();
      run_sum = '0;
      run_sq  = '0;
      seen    = 0;
      slot    = '0;
      tag     = '0;
      errors  = 0;
      onsets  = 0;
      markers = 0;
      foreach (score_hist[i]) begin
        score_hist[i] = '0;
        time_hist[i]  = '0;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction

    // ring slot k frames back from the current one
    function logic [RING_AW-1:0] back(int k);
      return slot - RING_AW'(k);
    endfunction

    function void drop(int k);
      logic [SCORE_W-1:0] v;
      v = score_hist[back(k)];
      run_sum = run_sum - SUM_W'(v);
      run_sq  = run_sq - SQ_W'(v) * SQ_W'(v);
    endfunction

    function void queue_beat(logic valid, logic [TIME_W-1:0] t,
                             logic [SCORE_W-1:0] s, logic done);
      onset_t e;
      e.peak_valid    = valid;
      e.onset_time_ms = t;
      e.onset_score   = s;
      e.onset_tag     = tag;
      e.stream_done   = done;
      due = {due, e};
    endfunction

    // local peak test, then exact d > 0 and 4*d^2 > 9*spread
    function void judge(int k, int n);
      longint s, l, r, sum, d, spread;
      s   = longint'(score_hist[back(k)]);
      l   = longint'(score_hist[back(k + 1)]);
      r   = longint'(score_hist[back(k - 1)]);
      sum = longint'(run_sum);
      if (s <= l || s < r) return;
      d = n * s - sum;
      if (d <= 0) return;
      spread = n * longint'(run_sq) - sum * sum;
      if (4 * d * d > 9 * spread)
        queue_beat(1'b1, time_hist[back(k)], score_hist[back(k)], 1'b0);
    endfunction

    function void frame_in(frame_t f);
      int j, n, lo, k;
      logic [SCORE_W-1:0] s;
      j = seen;
      s = SCORE_W'(f.total_flux) + SCORE_W'(f.chroma_flux)
        + SCORE_W'(f.percussive_energy);
      if (j >= 2 * HALF_WINDOW) drop(2 * HALF_WINDOW);
      score_hist[slot] = s;
      time_hist[slot]  = f.frame_time_ms;
      run_sum = run_sum + SUM_W'(s);
      run_sq  = run_sq + SQ_W'(s) * SQ_W'(s);
      if (j >= HALF_WINDOW) begin
        n = (j + 1 < 2 * HALF_WINDOW) ? j + 1 : 2 * HALF_WINDOW;
        judge(HALF_WINDOW - 1, n);
      end
      if (!f.end_of_stream) begin
        seen = (j < int'(CNT_MAX)) ? j + 1 : int'(CNT_MAX);
        slot = slot + 1'b1;
      end else begin
        // flush: window shrinks toward the stream end
        for (k = HALF_WINDOW - 2; k >= 1; k--) begin
          if (j >= k + HALF_WINDOW + 1) drop(k + HALF_WINDOW + 1);
          if (j > k) begin
            lo = (j >= k + HALF_WINDOW) ? j - k - HALF_WINDOW : 0;
            judge(k, j + 1 - lo);
          end
        end
        queue_beat(1'b0, '0, '0, 1'b1);
        run_sum = '0;
        run_sq  = '0;
        seen    = 0;
        slot    = '0;
      end
    endfunction

    function void check_field(string what, logic [TIME_W-1:0] want,
                              logic [TIME_W-1:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 30)
          $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      end
    endfunction

    function void result_out(onset_t got);
      onset_t want;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 30)
          $display("%0t: unexpected result beat: expected none, actual time %0h score %0h",
                   $time, got.onset_time_ms, got.onset_score);
      end else begin
        want = due.pop_front();
        if (want.stream_done) markers++;
        else onsets++;
        check_field("peak_valid", TIME_W'(want.peak_valid), TIME_W'(got.peak_valid));
        check_field("onset_time_ms", want.onset_time_ms, got.onset_time_ms);
        check_field("onset_score", TIME_W'(want.onset_score), TIME_W'(got.onset_score));
        check_field("onset_tag", TIME_W'(want.onset_tag), TIME_W'(got.onset_tag));
        check_field("stream_done", TIME_W'(want.stream_done), TIME_W'(got.stream_done));
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_write;
  logic [TAG_W-1:0]   cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic [FEAT_W-1:0]  total_flux;
  logic [FEAT_W-1:0]  chroma_flux;
  logic [FEAT_W-1:0]  percussive_energy;
  logic [TIME_W-1:0]  frame_time_ms;
  logic               end_of_stream;
  logic               out_valid;
  logic               out_stall;
  logic               peak_valid;
  logic [TIME_W-1:0]  onset_time_ms;
  logic [SCORE_W-1:0] onset_score;
  logic [TAG_W-1:0]   onset_tag;
  logic               stream_done;

  logic               squeeze_req;
  onset_tracker       tracker;
  int                 burst_left = 0;
  int                 frames_sent = 0;
  int                 streams = 0;
  int                 tag_writes = 0;

  adaptive_threshold_onset_picker dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .total_flux       (total_flux),
    .chroma_flux      (chroma_flux),
    .percussive_energy(percussive_energy),
    .frame_time_ms    (frame_time_ms),
    .end_of_stream    (end_of_stream),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .peak_valid       (peak_valid),
    .onset_time_ms    (onset_time_ms),
    .onset_score      (onset_score),
    .onset_tag        (onset_tag),
    .stream_done      (stream_done)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sender pacing: bursts of random length, short gaps in between
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 9);
    end
  endtask

  // One input beat; payload holds until accepted
  task automatic send_frame(frame_t f);
    in_valid          <= 1'b1;
    total_flux        <= f.total_flux;
    chroma_flux       <= f.chroma_flux;
    percussive_energy <= f.percussive_energy;
    frame_time_ms     <= f.frame_time_ms;
    end_of_stream     <= f.end_of_stream;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.frame_in(f);
    frames_sent++;
    pace();
  endtask

  task automatic send_feats(logic [FEAT_W-1:0] tf, logic [FEAT_W-1:0] cf,
                            logic [FEAT_W-1:0] pe, logic [TIME_W-1:0] t, logic eos);
    frame_t f;
    f.total_flux        = tf;
    f.chroma_flux       = cf;
    f.percussive_energy = pe;
    f.frame_time_ms     = t;
    f.end_of_stream     = eos;
    send_frame(f);
  endtask

  // Hold the sender until every queued result has come, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_tag(logic [TAG_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    tracker.tag = v;
    tag_writes++;
  endtask

  // Random stream: quiet noise, sparse spikes, repeated scores, silence
  task automatic play_stream(int len, int squeeze_at);
    frame_t f;
    int     noise_max;
    int     pick;
    int     i;
    case ($urandom_range(0, 2))
      0:       noise_max = 15;
      1:       noise_max = 255;
      default: noise_max = 4095;
    endcase
    f = '{default: '0};
    for (i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        f.total_flux        = FEAT_W'($urandom_range(0, noise_max));
        f.chroma_flux       = FEAT_W'($urandom_range(0, noise_max));
        f.percussive_energy = FEAT_W'($urandom_range(0, noise_max));
      end else if (pick < 84) begin
        if ($urandom_range(0, 7) == 0) begin
          f.total_flux        = '1;
          f.chroma_flux       = '1;
          f.percussive_energy = '1;
        end else begin
          f.total_flux        = FEAT_W'($urandom());
          f.chroma_flux       = FEAT_W'($urandom());
          f.percussive_energy = FEAT_W'($urandom());
        end
      end else if (pick >= 95) begin
        f.total_flux        = '0;
        f.chroma_flux       = '0;
        f.percussive_energy = '0;
      end
      // otherwise the previous features repeat: plateaus
      f.frame_time_ms = $urandom();
      f.end_of_stream = (i == len - 1);
      if (i == squeeze_at) squeeze_req <= 1'b1;
      send_frame(f);
    end
    streams++;
  endtask

  // Result side: stall moods, one long hold-off, check every accepted beat
  initial begin : result_sink
    int     mode;
    int     stretch;
    int     hold;
    bit     squeezed;
    onset_t got;
    out_stall <= 1'b0;
    mode     = 0;
    stretch  = 0;
    hold     = 0;
    squeezed = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        got.peak_valid    = peak_valid;
        got.onset_time_ms = onset_time_ms;
        got.onset_score   = onset_score;
        got.onset_tag     = onset_tag;
        got.stream_done   = stream_done;
        tracker.result_out(got);
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (squeeze_req === 1'b1 && !squeezed) begin
        squeezed = 1'b1;
        hold     = 600;
        out_stall <= 1'b1;
      end else begin
        if (stretch == 0) begin
          mode    = $urandom_range(0, 2);
          stretch = $urandom_range(20, 200);
        end
        stretch--;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 7) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    int i;
    int pick;
    int len;
    tracker = new();
    rst               <= 1'b1;
    cfg_write         <= 1'b0;
    cfg_data          <= '0;
    in_valid          <= 1'b0;
    total_flux        <= '0;
    chroma_flux       <= '0;
    percussive_energy <= '0;
    frame_time_ms     <= '0;
    end_of_stream     <= 1'b0;
    squeeze_req       <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_tag('1);

    // lone full-scale frame, then two and three frame streams
    send_feats('1, '1, '1, '1, 1'b1);
    send_feats('0, '0, '0, '0, 1'b0);
    send_feats('1, '1, '1, 32'h0000_0001, 1'b1);
    send_feats('0, '0, '0, 32'h0000_0010, 1'b0);
    send_feats('1, '1, '1, 32'h0000_0020, 1'b0);
    send_feats('0, '0, '0, 32'h0000_0030, 1'b1);
    // spikes at the first and next-to-last judged frames, a plateau, a peak
    for (i = 0; i < 15; i++) begin
      case (i)
        1:       send_feats(16'h0800, 16'h0800, 16'h0800, 32'hFFFF_0000 + i, 1'b0);
        5:       send_feats('1, '1, '1, 32'hFFFF_0000 + i, 1'b0);
        9, 10:   send_feats(16'h4000, 16'h4000, 16'h4000, 32'hFFFF_0000 + i, 1'b0);
        12:      send_feats(16'h0100, 16'h0100, 16'h0100, 32'hFFFF_0000 + i, 1'b0);
        13:      send_feats(16'h2000, 16'h2000, 16'h2000, 32'hFFFF_0000 + i, 1'b0);
        default: send_feats('0, '0, '0, 32'hFFFF_0000 + i, i == 14);
      endcase
    end
    streams += 4;
    drain();
    write_tag('0);

    // long stream saturates the frame counter and carries the hold-off
    play_stream(256 + $urandom_range(0, 8), 100);
    while (frames_sent < 300) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) len = $urandom_range(1, 3);
      else if (pick < 70) len = $urandom_range(4, 60);
      else len = $urandom_range(61, 130);
      if (len > 320 - frames_sent) len = 320 - frames_sent;
      play_stream(len, -1);
      if ($urandom_range(0, 3) == 0) begin
        drain();
        write_tag(TAG_W'($urandom_range(0, 15)));
      end
    end
    drain();
    repeat (24) @(posedge clk);

    $display("Covered %0d frames in %0d streams (short, windowed, saturating), %0d tag writes.",
             frames_sent, streams, tag_writes);
    $display("Checked %0d onset beats and %0d end markers, %0d failures.",
             tracker.onsets, tracker.markers, tracker.errors);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
